[hdl/mvs_pkg.sv]
// mvs_pkg: shared types, codes and constants for the motorized valve sequencer
// no dependencies; used by every module under hdl/
package mvs_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_OPENING = 3'd1,
    MODE_CLOSING = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_CLOSED  = 3'd4,
    MODE_FAULT   = 3'd5
  } mode_t;

  // command codes; 5 to 7 carry no meaning and start no mode change
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_OPEN  = 3'd1;
  localparam logic [2:0] ACT_CLOSE = 3'd2;
  localparam logic [2:0] ACT_STOP  = 3'd3;
  localparam logic [2:0] ACT_EMERG = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_OC_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SAMPLE   = 2'd2;
  localparam logic [1:0] CFG_BRAKE    = 2'd3;

  localparam logic [15:0] RST_TIMEOUT  = 16'd3000;
  localparam logic [11:0] RST_OC_LIMIT = 12'd1500;
  localparam logic [7:0]  RST_SAMPLE   = 8'd5;
  localparam logic [7:0]  RST_BRAKE    = 8'd5;

  localparam logic [5:0] F_OPEN        = 6'h01;
  localparam logic [5:0] F_CLOSED      = 6'h02;
  localparam logic [5:0] F_MOVING      = 6'h04;
  localparam logic [5:0] F_FAULT       = 6'h08;
  localparam logic [5:0] F_OVERCURRENT = 6'h10;
  localparam logic [5:0] F_TIMEOUT     = 6'h20;

  // ma = floor(mag * 2686 / 1000) == (mag * 2816476) >> 20, exact for mag <= 1023
  localparam logic [31:0] SCALE_MULT  = 32'd2816476;
  localparam int          SCALE_SHIFT = 20;

  localparam logic [15:0] MOTION_MAX = 16'hFFFF;
  localparam logic [7:0]  SAMPLE_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [11:0] overcurrent_limit_ma;
    logic [7:0]  sample_interval_ticks;
    logic [7:0]  brake_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        limit_open;
    logic        limit_closed;
    logic        driver_fault;
    logic [11:0] motor_ma;
  } tick_in_t;

  typedef struct packed {
    logic [2:0]  valve_state;
    logic [5:0]  status_flags;
    logic [11:0] motor_ma;
    logic        bridge_in1;
    logic        bridge_in2;
    logic        driver_awake;
  } tick_out_t;

  // the part of the state that a mode change touches
  typedef struct packed {
    mode_t       mode;
    logic [5:0]  flags;
    logic [15:0] motion_ticks;
    logic [7:0]  brake_left;
  } move_st_t;

  function automatic move_st_t go_to(move_st_t s, mode_t nxt, logic [7:0] brake);
    move_st_t r;
    r = s;
    if (s.mode != nxt) begin
      r.mode = nxt;
      case (nxt)
        MODE_OPENING, MODE_CLOSING: begin
          r.flags = (s.flags & ~(F_OPEN | F_CLOSED | F_FAULT | F_OVERCURRENT | F_TIMEOUT))
                    | F_MOVING;
          r.motion_ticks = '0;
        end
        MODE_OPEN: begin
          r.brake_left = brake;
          r.flags = (s.flags & ~F_MOVING) | F_OPEN;
        end
        MODE_CLOSED: begin
          r.brake_left = brake;
          r.flags = (s.flags & ~F_MOVING) | F_CLOSED;
        end
        MODE_FAULT: begin
          r.flags = (s.flags & ~F_MOVING) | F_FAULT;
        end
        default: begin
          r.flags = s.flags & ~F_MOVING;
        end
      endcase
    end
    return r;
  endfunction

endpackage

[hdl/motorized_valve_sequencer_core.sv]
// motorized_valve_sequencer_core: top level of the valve sequencer
// depends on mvs_pkg, mvs_cfg_regs, mvs_scale, mvs_tick
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | action, limits, driver fault, current sample
//   out_    | output    | out_valid / out_stall| state, flags, current, bridge, awake
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// one tick transaction per cycle unless out_stall holds the result: input register,
// tick update, result register; a taken transaction's result reaches the outputs from the result register
// the current scaling multiply sits ahead of the input register
// rst_n clears state, config to defaults and both valid flags
// a stalled result holds; the input register still takes a transaction when it is empty
module motorized_valve_sequencer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic               in_limit_open,
  input  logic               in_limit_closed,
  input  logic               in_driver_fault,
  input  logic signed [10:0] in_current_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_valve_state,
  output logic [5:0]         out_status_flags,
  output logic [11:0]        out_current_ma,
  output logic               out_bridge_in1,
  output logic               out_bridge_in2,
  output logic               out_driver_awake,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  mvs_pkg::cfg_t      cfg;
  mvs_pkg::tick_in_t  tin_r, tin_nxt;
  mvs_pkg::tick_out_t res_r, tout;
  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [11:0]        scaled_ma;
  logic               in_take;
  logic               advance;

  mvs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mvs_scale u_scale (
    .sample   (in_current_sample),
    .motor_ma (scaled_ma)
  );

  mvs_tick u_tick (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cfg   (cfg),
    .tin   (tin_r),
    .tout  (tout)
  );

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    tin_nxt.action       = in_action;
    tin_nxt.limit_open   = in_limit_open;
    tin_nxt.limit_closed = in_limit_closed;
    tin_nxt.driver_fault = in_driver_fault;
    tin_nxt.motor_ma     = scaled_ma;

    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tin_r <= tin_nxt;
    end
    if (advance) begin
      res_r <= tout;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valve_state  = res_r.valve_state;
  assign out_status_flags = res_r.status_flags;
  assign out_current_ma   = res_r.motor_ma;
  assign out_bridge_in1   = res_r.bridge_in1;
  assign out_bridge_in2   = res_r.bridge_in2;
  assign out_driver_awake = res_r.driver_awake;

endmodule

[hdl/mvs_cfg_regs.sv]
// mvs_cfg_regs: the four configuration registers and their write decode
// depends on mvs_pkg
module mvs_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output mvs_pkg::cfg_t cfg
);

  mvs_pkg::cfg_t cfg_r;
  mvs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mvs_pkg::CFG_TIMEOUT:  cfg_nxt.timeout_ticks         = cfg_wdata;
        mvs_pkg::CFG_OC_LIMIT: cfg_nxt.overcurrent_limit_ma  = cfg_wdata[11:0];
        mvs_pkg::CFG_SAMPLE:   cfg_nxt.sample_interval_ticks = cfg_wdata[7:0];
        mvs_pkg::CFG_BRAKE:    cfg_nxt.brake_ticks           = cfg_wdata[7:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks         <= mvs_pkg::RST_TIMEOUT;
      cfg_r.overcurrent_limit_ma  <= mvs_pkg::RST_OC_LIMIT;
      cfg_r.sample_interval_ticks <= mvs_pkg::RST_SAMPLE;
      cfg_r.brake_ticks           <= mvs_pkg::RST_BRAKE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/mvs_scale.sv]
// mvs_scale: converts a signed current-sense reading to milliamps
// depends on mvs_pkg; negative readings clamp to zero
module mvs_scale (
  input  logic signed [10:0] sample,
  output logic [11:0]        motor_ma
);

  logic [9:0]  mag;
  logic [31:0] prod;

  assign mag  = sample[10] ? 10'd0 : sample[9:0];
  // max product 1023 * 2816476 stays below 2^32
  assign prod = 32'(mag) * mvs_pkg::SCALE_MULT;
  assign motor_ma = prod[mvs_pkg::SCALE_SHIFT +: 12];

endmodule

[hdl/mvs_tick.sv]
// mvs_tick: sequencer state registers and the per-tick update logic
// depends on mvs_pkg; state advances only when step is high
module mvs_tick (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  mvs_pkg::cfg_t       cfg,
  input  mvs_pkg::tick_in_t   tin,
  output mvs_pkg::tick_out_t  tout
);

  mvs_pkg::move_st_t mv_r, mv_nxt;
  logic              started_r, started_nxt;
  logic [11:0]       current_r, current_nxt;
  logic [7:0]        tss_r, tss_nxt;
  logic [2:0]        held_r, held_nxt;

  always_comb begin
    mvs_pkg::move_st_t s;
    mvs_pkg::mode_t    target;
    logic              do_go;
    logic [2:0]        cmd;
    logic              moving;
    logic              at_end;

    s           = mv_r;
    started_nxt = started_r;
    current_nxt = current_r;
    tss_nxt     = tss_r;
    held_nxt    = held_r;
    target      = mvs_pkg::MODE_IDLE;
    do_go       = 1'b0;
    cmd         = mvs_pkg::ACT_NONE;
    at_end      = 1'b0;

    // first tick after reset: classify from the switches, open wins
    if (!started_r) begin
      started_nxt = 1'b1;
      if (tin.limit_open) begin
        s.mode  = mvs_pkg::MODE_OPEN;
        s.flags = s.flags | mvs_pkg::F_OPEN;
      end else if (tin.limit_closed) begin
        s.mode  = mvs_pkg::MODE_CLOSED;
        s.flags = s.flags | mvs_pkg::F_CLOSED;
      end else begin
        s.mode = mvs_pkg::MODE_IDLE;
      end
    end

    if (s.brake_left != 8'd0) begin
      // commands wait while braking, latest one kept
      if (tin.action != mvs_pkg::ACT_NONE) begin
        held_nxt = tin.action;
      end
      s.brake_left = s.brake_left - 8'd1;
    end else begin
      cmd      = (tin.action != mvs_pkg::ACT_NONE) ? tin.action : held_r;
      held_nxt = mvs_pkg::ACT_NONE;
      case (cmd)
        mvs_pkg::ACT_OPEN: begin
          do_go  = !tin.limit_open;
          target = mvs_pkg::MODE_OPENING;
        end
        mvs_pkg::ACT_CLOSE: begin
          do_go  = !tin.limit_closed;
          target = mvs_pkg::MODE_CLOSING;
        end
        mvs_pkg::ACT_STOP: begin
          do_go = 1'b1;
          if (tin.limit_open) begin
            target = mvs_pkg::MODE_OPEN;
          end else if (tin.limit_closed) begin
            target = mvs_pkg::MODE_CLOSED;
          end else begin
            target = mvs_pkg::MODE_IDLE;
          end
        end
        mvs_pkg::ACT_EMERG: begin
          do_go  = 1'b1;
          target = mvs_pkg::MODE_CLOSING;
        end
        default: begin
          do_go = 1'b0;
        end
      endcase
      if (do_go) begin
        s = mvs_pkg::go_to(s, target, cfg.brake_ticks);
      end
    end

    moving = (s.mode == mvs_pkg::MODE_OPENING) || (s.mode == mvs_pkg::MODE_CLOSING);

    if (moving && (tss_r >= cfg.sample_interval_ticks)) begin
      current_nxt = tin.motor_ma;
      tss_nxt     = 8'd0;
    end

    // motion checks: end switch, timeout, overcurrent, driver fault
    if (moving) begin
      at_end = (s.mode == mvs_pkg::MODE_OPENING) ? tin.limit_open : tin.limit_closed;
      if (at_end) begin
        s = mvs_pkg::go_to(s, (s.mode == mvs_pkg::MODE_OPENING) ? mvs_pkg::MODE_OPEN
                                                                : mvs_pkg::MODE_CLOSED,
                           cfg.brake_ticks);
      end else if (s.motion_ticks > cfg.timeout_ticks) begin
        s.flags = s.flags | mvs_pkg::F_TIMEOUT;
        s = mvs_pkg::go_to(s, mvs_pkg::MODE_FAULT, cfg.brake_ticks);
      end else if (current_nxt > cfg.overcurrent_limit_ma) begin
        s.flags = s.flags | mvs_pkg::F_OVERCURRENT;
        s = mvs_pkg::go_to(s, mvs_pkg::MODE_FAULT, cfg.brake_ticks);
      end else if (tin.driver_fault) begin
        s.flags = s.flags | mvs_pkg::F_FAULT;
        s = mvs_pkg::go_to(s, mvs_pkg::MODE_FAULT, cfg.brake_ticks);
      end
    end

    tout.valve_state  = s.mode;
    tout.status_flags = s.flags;
    tout.motor_ma     = current_nxt;
    tout.bridge_in1   = 1'b0;
    tout.bridge_in2   = 1'b0;
    tout.driver_awake = 1'b0;
    if (s.mode == mvs_pkg::MODE_OPENING) begin
      tout.bridge_in1   = 1'b1;
      tout.driver_awake = 1'b1;
    end else if (s.mode == mvs_pkg::MODE_CLOSING) begin
      tout.bridge_in2   = 1'b1;
      tout.driver_awake = 1'b1;
    end else if (s.brake_left != 8'd0) begin
      tout.bridge_in1   = 1'b1;
      tout.bridge_in2   = 1'b1;
      tout.driver_awake = 1'b1;
    end

    // counters saturate
    if (((s.mode == mvs_pkg::MODE_OPENING) || (s.mode == mvs_pkg::MODE_CLOSING))
        && (s.motion_ticks != mvs_pkg::MOTION_MAX)) begin
      s.motion_ticks = s.motion_ticks + 16'd1;
    end
    if (tss_nxt != mvs_pkg::SAMPLE_MAX) begin
      tss_nxt = tss_nxt + 8'd1;
    end

    mv_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r.mode         <= mvs_pkg::MODE_IDLE;
      mv_r.flags        <= '0;
      mv_r.motion_ticks <= '0;
      mv_r.brake_left   <= '0;
      started_r         <= 1'b0;
      current_r         <= '0;
      tss_r             <= mvs_pkg::SAMPLE_MAX;
      held_r            <= mvs_pkg::ACT_NONE;
    end else if (step) begin
      mv_r      <= mv_nxt;
      started_r <= started_nxt;
      current_r <= current_nxt;
      tss_r     <= tss_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for motorized_valve_sequencer_core
// depends on mvs_pkg and the core; a local tick predictor scores every result
module testbench;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_TICKS = 90;
  localparam int LONG_RUN_TICKS = 40;
  localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;
  localparam mvs_pkg::tick_out_t NO_WANT = '0;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_action = mvs_pkg::ACT_NONE;
  logic               in_limit_open = 1'b0;
  logic               in_limit_closed = 1'b0;
  logic               in_driver_fault = 1'b0;
  logic signed [10:0] in_current_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_valve_state;
  logic [5:0]         out_status_flags;
  logic [11:0]        out_current_ma;
  logic               out_bridge_in1;
  logic               out_bridge_in2;
  logic               out_driver_awake;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = mvs_pkg::CFG_TIMEOUT;
  logic [15:0]        cfg_wdata = '0;

  motorized_valve_sequencer_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_limit_open     (in_limit_open),
    .in_limit_closed   (in_limit_closed),
    .in_driver_fault   (in_driver_fault),
    .in_current_sample (in_current_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_valve_state   (out_valve_state),
    .out_status_flags  (out_status_flags),
    .out_current_ma    (out_current_ma),
    .out_bridge_in1    (out_bridge_in1),
    .out_bridge_in2    (out_bridge_in2),
    .out_driver_awake  (out_driver_awake),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // valve tracking state
  mvs_pkg::mode_t vmode;
  logic        vstarted;
  logic [5:0]  vflags;
  logic [11:0] vcurrent;
  logic [15:0] vmotion;
  logic [7:0]  vsince;
  logic [7:0]  vbrake_left;
  logic [2:0]  vheld;
  logic [15:0] c_timeout;
  logic [11:0] c_oc_limit;
  logic [7:0]  c_sample;
  logic [7:0]  c_brake;

  mvs_pkg::tick_out_t valve_reports_due[$];
  int mismatches, n_ticks, n_checked, n_in_stalls, cycle_count;
  int n_timeouts, n_overcurrents, n_drv_faults, n_arrivals, n_held_run;
  int burst_left, pos, travel;
  bit steady, hold_off_req;

  function automatic bit moving();
    return (vmode == mvs_pkg::MODE_OPENING) || (vmode == mvs_pkg::MODE_CLOSING);
  endfunction

  task automatic enter_mode(input mvs_pkg::mode_t nxt);
    if (vmode != nxt) begin
      vmode = nxt;
      case (nxt)
        mvs_pkg::MODE_OPENING, mvs_pkg::MODE_CLOSING: begin
          vflags = (vflags & ~(mvs_pkg::F_OPEN | mvs_pkg::F_CLOSED | mvs_pkg::F_FAULT
                               | mvs_pkg::F_OVERCURRENT | mvs_pkg::F_TIMEOUT))
                   | mvs_pkg::F_MOVING;
          vmotion = '0;
        end
        mvs_pkg::MODE_OPEN: begin
          vbrake_left = c_brake;
          vflags = (vflags & ~mvs_pkg::F_MOVING) | mvs_pkg::F_OPEN;
        end
        mvs_pkg::MODE_CLOSED: begin
          vbrake_left = c_brake;
          vflags = (vflags & ~mvs_pkg::F_MOVING) | mvs_pkg::F_CLOSED;
        end
        mvs_pkg::MODE_FAULT: vflags = (vflags & ~mvs_pkg::F_MOVING) | mvs_pkg::F_FAULT;
        default: vflags = vflags & ~mvs_pkg::F_MOVING;
      endcase
    end
  endtask

  task automatic run_command(input logic [2:0] cmd, input logic lo, input logic lc);
    case (cmd)
      mvs_pkg::ACT_OPEN: if (!lo) enter_mode(mvs_pkg::MODE_OPENING);
      mvs_pkg::ACT_CLOSE: if (!lc) enter_mode(mvs_pkg::MODE_CLOSING);
      mvs_pkg::ACT_STOP: begin
        // open switch wins when both are active
        if (lo) enter_mode(mvs_pkg::MODE_OPEN);
        else if (lc) enter_mode(mvs_pkg::MODE_CLOSED);
        else enter_mode(mvs_pkg::MODE_IDLE);
      end
      mvs_pkg::ACT_EMERG: enter_mode(mvs_pkg::MODE_CLOSING);
      default: ;
    endcase
  endtask

  task automatic advance_valve(input logic [2:0] act, input logic lo, input logic lc,
                               input logic df, input logic signed [10:0] smp,
                               output mvs_pkg::tick_out_t r);
    int mag;
    int ma;
    logic at_end;
    logic [2:0] cmd;
    if (!vstarted) begin
      vstarted = 1'b1;
      if (lo) begin
        vmode = mvs_pkg::MODE_OPEN;
        vflags |= mvs_pkg::F_OPEN;
      end else if (lc) begin
        vmode = mvs_pkg::MODE_CLOSED;
        vflags |= mvs_pkg::F_CLOSED;
      end else begin
        vmode = mvs_pkg::MODE_IDLE;
      end
    end
    if (vbrake_left != 0) begin
      if (act != mvs_pkg::ACT_NONE) vheld = act;
      vbrake_left--;
    end else begin
      if (act == mvs_pkg::ACT_NONE && vheld != mvs_pkg::ACT_NONE) n_held_run++;
      cmd = (act != mvs_pkg::ACT_NONE) ? act : vheld;
      vheld = mvs_pkg::ACT_NONE;
      run_command(cmd, lo, lc);
    end
    if (moving() && vsince >= c_sample) begin
      mag = (smp < 0) ? 0 : int'(smp);
      ma = mag * 2686 / 1000;
      if (ma > 4095) ma = 4095;
      vcurrent = 12'(ma);
      vsince = '0;
    end
    if (moving()) begin
      at_end = (vmode == mvs_pkg::MODE_OPENING) ? lo : lc;
      if (at_end) begin
        n_arrivals++;
        if (vmode == mvs_pkg::MODE_OPENING) enter_mode(mvs_pkg::MODE_OPEN);
        else enter_mode(mvs_pkg::MODE_CLOSED);
      end else if (vmotion > c_timeout) begin
        n_timeouts++;
        vflags |= mvs_pkg::F_TIMEOUT;
        enter_mode(mvs_pkg::MODE_FAULT);
      end else if (vcurrent > c_oc_limit) begin
        n_overcurrents++;
        vflags |= mvs_pkg::F_OVERCURRENT;
        enter_mode(mvs_pkg::MODE_FAULT);
      end else if (df) begin
        n_drv_faults++;
        vflags |= mvs_pkg::F_FAULT;
        enter_mode(mvs_pkg::MODE_FAULT);
      end
    end
    r.valve_state = vmode;
    r.status_flags = vflags;
    r.motor_ma = vcurrent;
    r.bridge_in1 = (vmode == mvs_pkg::MODE_OPENING) || (!moving() && vbrake_left != 0);
    r.bridge_in2 = (vmode == mvs_pkg::MODE_CLOSING) || (!moving() && vbrake_left != 0);
    r.driver_awake = moving() || (vbrake_left != 0);
    if (moving() && vmotion != mvs_pkg::MOTION_MAX) vmotion++;
    if (vsince != mvs_pkg::SAMPLE_MAX) vsince++;
  endtask

  function automatic bit same_result(input mvs_pkg::tick_out_t a,
                                     input mvs_pkg::tick_out_t b);
    return (a.valve_state === b.valve_state) && (a.status_flags === b.status_flags) &&
           (a.motor_ma === b.motor_ma) && (a.bridge_in1 === b.bridge_in1) &&
           (a.bridge_in2 === b.bridge_in2) && (a.driver_awake === b.driver_awake);
  endfunction

  task automatic log_mismatch(input string what, input mvs_pkg::tick_out_t want,
                              input mvs_pkg::tick_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t: want state %0d flags %02h ma %0d br %b%b awake %b",
               what, $realtime, want.valve_state, want.status_flags, want.motor_ma,
               want.bridge_in1, want.bridge_in2, want.driver_awake);
      $display("  got state %0d flags %02h ma %0d br %b%b awake %b",
               got.valve_state, got.status_flags, got.motor_ma, got.bridge_in1,
               got.bridge_in2, got.driver_awake);
    end
  endtask

  // one tick transaction, then maybe a gap between bursts
  task automatic offer_tick(input logic [2:0] act, input logic lo, input logic lc,
                            input logic df, input logic signed [10:0] smp,
                            output mvs_pkg::tick_out_t predicted);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_limit_open <= lo;
    in_limit_closed <= lc;
    in_driver_fault <= df;
    in_current_sample <= smp;
    do @(posedge clk); while (in_stall);
    advance_valve(act, lo, lc, df, smp, predicted);
    valve_reports_due.push_back(predicted);
    n_ticks++;
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (valve_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] t, input logic [11:0] oc,
                              input logic [7:0] si, input logic [7:0] br);
    settle();
    put_reg(mvs_pkg::CFG_TIMEOUT, t);
    put_reg(mvs_pkg::CFG_OC_LIMIT, {4'b0, oc});
    put_reg(mvs_pkg::CFG_SAMPLE, {8'b0, si});
    put_reg(mvs_pkg::CFG_BRAKE, {8'b0, br});
    cfg_we <= 1'b0;
    c_timeout = t;
    c_oc_limit = oc;
    c_sample = si;
    c_brake = br;
  endtask

  // a valve that travels while driven, with some switch noise and random commands
  task automatic random_phase(input int count);
    logic lo, lc, df;
    logic [2:0] act;
    logic signed [10:0] smp;
    mvs_pkg::tick_out_t p;
    int r;
    travel = $urandom_range(3, 40);
    pos = $urandom_range(0, travel);
    repeat (count) begin
      if (vmode == mvs_pkg::MODE_OPENING && pos < travel) pos++;
      else if (vmode == mvs_pkg::MODE_CLOSING && pos > 0) pos--;
      lo = (pos == travel);
      lc = (pos == 0);
      if ($urandom_range(0, 99) < 8) begin
        lo = 1'($urandom_range(0, 1));
        lc = 1'($urandom_range(0, 1));
      end
      r = $urandom_range(0, 99);
      if (r < 55) act = mvs_pkg::ACT_NONE;
      else if (r < 67) act = mvs_pkg::ACT_OPEN;
      else if (r < 79) act = mvs_pkg::ACT_CLOSE;
      else if (r < 86) act = mvs_pkg::ACT_STOP;
      else if (r < 91) act = mvs_pkg::ACT_EMERG;
      else if (r < 95) act = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
      else act = mvs_pkg::ACT_NONE;
      df = ($urandom_range(0, 99) < 3);
      if ($urandom_range(0, 99) < 80) smp = 11'($urandom_range(0, 600));
      else smp = 11'($urandom);
      offer_tick(act, lo, lc, df, smp, p);
    end
  endtask

  typedef struct packed {
    logic [2:0]         act;
    logic               lo;
    logic               lc;
    logic               df;
    logic signed [10:0] smp;
    logic               typed;
    mvs_pkg::tick_out_t want;
  } step_row_t;

  // runs on reset register values: timeout 3000, limit 1500, sample 5, brake 5
  step_row_t steps [25] = '{
    // both switches on the first tick: classified open
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b1, 1'b0, 11'sd0, 1'b1,
      '{mvs_pkg::MODE_OPEN, mvs_pkg::F_OPEN, 12'd0, 1'b0, 1'b0, 1'b0}},
    // full-scale current trips the limit on the first sample
    '{mvs_pkg::ACT_OPEN, 1'b0, 1'b0, 1'b0, 11'sd1023, 1'b1,
      '{mvs_pkg::MODE_FAULT, mvs_pkg::F_FAULT | mvs_pkg::F_OVERCURRENT, 12'd2747,
        1'b0, 1'b0, 1'b0}},
    // old current carried into the new motion
    '{mvs_pkg::ACT_CLOSE, 1'b0, 1'b0, 1'b0, -11'sd1024, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b0, 1'b0, 1'b1, -11'sd1, 1'b0, NO_WANT},
    '{ACT_UNDEF_LO, 1'b0, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b0, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    // negative reading clamps to zero
    '{mvs_pkg::ACT_CLOSE, 1'b0, 1'b0, 1'b0, -11'sd1024, 1'b1,
      '{mvs_pkg::MODE_CLOSING, mvs_pkg::F_MOVING, 12'd0, 1'b0, 1'b1, 1'b1}},
    '{mvs_pkg::ACT_NONE, 1'b0, 1'b0, 1'b1, 11'sd0, 1'b1,
      '{mvs_pkg::MODE_FAULT, mvs_pkg::F_FAULT, 12'd0, 1'b0, 1'b0, 1'b0}},
    '{mvs_pkg::ACT_EMERG, 1'b1, 1'b0, 1'b0, 11'sd100, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_STOP, 1'b1, 1'b1, 1'b0, 11'sd200, 1'b1,
      '{mvs_pkg::MODE_OPEN, mvs_pkg::F_OPEN, 12'd0, 1'b1, 1'b1, 1'b1}},
    // commands during the brake are held, latest wins
    '{mvs_pkg::ACT_CLOSE, 1'b1, 1'b1, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{ACT_UNDEF_HI, 1'b1, 1'b1, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_OPEN, 1'b1, 1'b1, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b1, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b1, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b0, 1'b0, 1'b0, 11'sd300, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_OPEN, 1'b0, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_CLOSE, 1'b1, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b1, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    // fresh command right after the brake beats the held one
    '{mvs_pkg::ACT_STOP, 1'b1, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT},
    '{mvs_pkg::ACT_NONE, 1'b0, 1'b0, 1'b0, 11'sd0, 1'b0, NO_WANT}
  };

  always @(posedge clk) begin : result_check
    mvs_pkg::tick_out_t got;
    mvs_pkg::tick_out_t want;
    if (rst_n && in_valid && in_stall) n_in_stalls++;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_valve_state, out_status_flags, out_current_ma,
              out_bridge_in1, out_bridge_in2, out_driver_awake};
      n_checked++;
      if (valve_reports_due.size() == 0) begin
        log_mismatch("unexpected result", NO_WANT, got);
      end else begin
        want = valve_reports_due.pop_front();
        if (!same_result(want, got)) log_mismatch("result differs", want, got);
      end
    end
  end

  initial begin : receiver
    int pct;
    int span;
    @(posedge clk);
    forever begin
      // long hold so the core backs up and stalls its input
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 50;
        default: pct = 85;
      endcase
      span = $urandom_range(4, 64);
      repeat (span) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    mvs_pkg::tick_out_t p;
    int k;
    vmode = mvs_pkg::MODE_IDLE;
    vstarted = 1'b0;
    vflags = '0;
    vcurrent = '0;
    vmotion = '0;
    vsince = mvs_pkg::SAMPLE_MAX;
    vbrake_left = '0;
    vheld = mvs_pkg::ACT_NONE;
    c_timeout = mvs_pkg::RST_TIMEOUT;
    c_oc_limit = mvs_pkg::RST_OC_LIMIT;
    c_sample = mvs_pkg::RST_SAMPLE;
    c_brake = mvs_pkg::RST_BRAKE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < 25; k++) begin
      offer_tick(steps[k].act, steps[k].lo, steps[k].lc, steps[k].df, steps[k].smp, p);
      if (steps[k].typed && !same_result(steps[k].want, p))
        log_mismatch("table row disagrees", steps[k].want, p);
    end

    // low extremes: timeout of one, zero current limit, zero sample interval and zero brake
    program_regs(16'd1, 12'd0, 8'd0, 8'd0);
    hold_off_req = 1'b1;
    random_phase(PHASE_TICKS);
    program_regs(mvs_pkg::MOTION_MAX, 12'hFFF, mvs_pkg::SAMPLE_MAX, 8'hFF);
    random_phase(PHASE_TICKS);
    repeat (4) begin
      program_regs(16'($urandom_range(8, 80)), 12'($urandom_range(300, 2800)),
                   8'($urandom_range(0, 12)), 8'($urandom_range(0, 10)));
      random_phase(PHASE_TICKS);
    end

    // one unbroken motion with the timeout register at its top value
    program_regs(mvs_pkg::MOTION_MAX, 12'hFFF, 8'($urandom_range(1, 20)), 8'd0);
    steady = 1'b1;
    repeat (12) offer_tick(mvs_pkg::ACT_NONE, 1'b0, 1'b0, 1'b0, 11'sd0, p);
    offer_tick(mvs_pkg::ACT_CLOSE, 1'b0, 1'b0, 1'b0, 11'sd100, p);
    repeat (LONG_RUN_TICKS)
      offer_tick(mvs_pkg::ACT_NONE, 1'b0, 1'b0, 1'b0, 11'($urandom_range(0, 1023)), p);
    offer_tick(mvs_pkg::ACT_NONE, 1'b0, 1'b1, 1'b0, 11'sd0, p);
    steady = 1'b0;

    settle();
    $display("ticks %0d, results checked %0d, ends reached %0d, held commands run %0d",
             n_ticks, n_checked, n_arrivals, n_held_run);
    $display("faults: timeout %0d, overcurrent %0d, driver %0d; input stall cycles %0d",
             n_timeouts, n_overcurrents, n_drv_faults, n_in_stalls);
    if (mismatches == 0 && valve_reports_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mvs_pkg.sv
hdl/mvs_cfg_regs.sv
hdl/mvs_scale.sv
hdl/mvs_tick.sv
hdl/motorized_valve_sequencer_core.sv
bench/testbench.sv
